FILE: rtl/fdr_pkg.sv
// fdr_pkg: shared types and codes for the feature distance top-n ranker
// payload structs, sorted-list entry and command types, operation and register codes
// no dependencies
`timescale 1ns / 1ps

package fdr_pkg;

   localparam int SCORE_W = 41;
   localparam int ID_W    = 16;
   localparam int BIN_W   = 16;
   localparam int TERM_W  = 32;

   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   localparam logic [1:0] OP_LOAD_QUERY = 2'd0;
   localparam logic [1:0] OP_DATABASE   = 2'd1;
   localparam logic [1:0] OP_FINISH     = 2'd2;

   localparam logic [1:0] CSR_METRIC_MODE   = 2'd0;
   localparam logic [1:0] CSR_VECTOR_LENGTH = 2'd1;
   localparam logic [1:0] CSR_TOP_COUNT     = 2'd2;

   typedef struct packed {
      logic [1:0]       operation;
      logic [BIN_W-1:0] bin_value;
      logic [ID_W-1:0]  image_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    match_id;
      logic [SCORE_W-1:0] match_score;
      logic [3:0]         rank_position;
      logic               rank_last;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [SCORE_W-1:0] score;
      logic [ID_W-1:0]    id;
   } entry_type;

   typedef struct packed {
      logic               insert;
      logic               shift_up;
      logic               clear;
      logic               mode;
      logic [SCORE_W-1:0] score;
      logic [ID_W-1:0]    id;
   } list_cmd_type;

   typedef struct packed {
      logic               ins;
      logic               fin;
      logic [SCORE_W-1:0] score;
      logic [ID_W-1:0]    id;
   } score_evt_type;

endpackage

FILE: rtl/fdr_score_path.sv
// fdr_score_path: query bin memory, shared bin counter, per-bin term and score accumulator
// three stages: memory access, term, saturating accumulate
// depends on fdr_pkg
`timescale 1ns / 1ps

module fdr_score_path
   import fdr_pkg::*;
#(
   parameter int BINS = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_take,
   input  req_type             item,
   input  logic                metric_mode,
   input  logic [9:0]          vector_length,
   output score_evt_type       evt,
   output logic                fin_busy
);

   localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int LW = (AW + 1 > 10) ? AW + 1 : 10;

   logic [BIN_W-1:0] mem [BINS];

   logic [AW-1:0] pos_ff, pos_in;
   logic [LW-1:0] eff_len;
   logic [LW-1:0] pos_inc;
   logic          last_bin;

   // stage 1
   logic             s1_valid_ff, s1_fin_ff, s1_last_ff;
   logic [BIN_W-1:0] s1_bin_ff, q_ff;
   logic [ID_W-1:0]  s1_id_ff;
   // stage 2
   logic              s2_valid_ff, s2_fin_ff, s2_last_ff;
   logic [ID_W-1:0]   s2_id_ff;
   logic [TERM_W-1:0] term_ff, term_in;
   logic [BIN_W-1:0]  diff;
   // stage 3
   logic [SCORE_W-1:0] acc_ff, acc_in, acc_sat;
   logic [SCORE_W:0]   acc_sum;
   score_evt_type      evt_ff, evt_in;

   always_comb begin
      if (vector_length == 10'd0) begin
         eff_len = LW'(1);
      end else if (LW'(vector_length) > LW'(BINS)) begin
         eff_len = LW'(BINS);
      end else begin
         eff_len = LW'(vector_length);
      end
      pos_inc  = LW'(pos_ff) + LW'(1);
      last_bin = (pos_inc >= eff_len);
      pos_in   = pos_ff;
      if (item_take) begin
         unique case (item.operation)
            OP_LOAD_QUERY, OP_DATABASE: begin
               pos_in = last_bin ? '0 : pos_inc[AW-1:0];
            end
            OP_FINISH: begin
               pos_in = '0;
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && item.operation == OP_LOAD_QUERY) begin
         mem[pos_ff] <= item.bin_value;
      end
      q_ff <= mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fin_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= item_take && (item.operation == OP_DATABASE);
         s1_fin_ff   <= item_take && (item.operation == OP_FINISH);
      end
      s1_last_ff <= last_bin;
      s1_bin_ff  <= item.bin_value;
      s1_id_ff   <= item.image_id;
   end

   always_comb begin
      diff = (q_ff > s1_bin_ff) ? (q_ff - s1_bin_ff) : (s1_bin_ff - q_ff);
      if (metric_mode) begin
         term_in = diff * diff;
      end else begin
         term_in = TERM_W'((q_ff < s1_bin_ff) ? q_ff : s1_bin_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_fin_ff   <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         s2_fin_ff   <= s1_fin_ff;
      end
      s2_last_ff <= s1_last_ff;
      s2_id_ff   <= s1_id_ff;
      term_ff    <= term_in;
   end

   always_comb begin
      acc_sum = {1'b0, acc_ff} + (SCORE_W + 1)'(term_ff);
      acc_sat = acc_sum[SCORE_W] ? SCORE_MAX : acc_sum[SCORE_W-1:0];
      acc_in  = acc_ff;
      evt_in  = '0;
      evt_in.score = acc_sat;
      evt_in.id    = s2_id_ff;
      if (s2_fin_ff) begin
         acc_in     = '0;
         evt_in.fin = 1'b1;
      end else if (s2_valid_ff) begin
         if (s2_last_ff) begin
            acc_in     = '0;
            evt_in.ins = 1'b1;
         end else begin
            acc_in = acc_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         evt_ff.ins <= 1'b0;
         evt_ff.fin <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         evt_ff.ins <= evt_in.ins;
         evt_ff.fin <= evt_in.fin;
      end
      evt_ff.score <= evt_in.score;
      evt_ff.id    <= evt_in.id;
   end

   assign evt      = evt_ff;
   assign fin_busy = s1_fin_ff | s2_fin_ff | evt_ff.fin;

endmodule

FILE: rtl/fdr_rank_cell.sv
// fdr_rank_cell: one slot of the sorted match list
// takes a new score, its left neighbor or its right neighbor as the list command says
// depends on fdr_pkg
`timescale 1ns / 1ps

module fdr_rank_cell
   import fdr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  list_cmd_type cmd,
   input  entry_type    left_entry,
   input  entry_type    right_entry,
   input  logic         place_in,
   output entry_type    entry,
   output logic         place_out
);

   entry_type entry_ff, entry_in;
   logic      better;
   logic      goes_here;

   always_comb begin
      better    = cmd.mode ? (cmd.score < entry_ff.score) : (cmd.score > entry_ff.score);
      goes_here = !entry_ff.valid || better;
      place_out = place_in || goes_here;
      entry_in  = entry_ff;
      if (cmd.clear) begin
         entry_in.valid = 1'b0;
      end else if (cmd.shift_up) begin
         entry_in = right_entry;
      end else if (cmd.insert) begin
         if (place_in) begin
            entry_in = left_entry;
         end else if (goes_here) begin
            entry_in.valid = 1'b1;
            entry_in.score = cmd.score;
            entry_in.id    = cmd.id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.score <= entry_in.score;
      entry_ff.id    <= entry_in.id;
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/fdr_rank_list.sv
// fdr_rank_list: row of rank cells forming the sorted match list, best at slot 0
// exposes slot 1, the best reported match
// depends on fdr_pkg, fdr_rank_cell
`timescale 1ns / 1ps

module fdr_rank_list
   import fdr_pkg::*;
#(
   parameter int DEPTH = 17
) (
   input  logic         clock,
   input  logic         reset,
   input  list_cmd_type cmd,
   output entry_type    report_entry
);

   entry_type row   [DEPTH+2];
   logic      place [DEPTH+1];

   assign row[0]       = '0;
   assign row[DEPTH+1] = '0;
   assign place[0]     = 1'b0;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      fdr_rank_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (row[k]),
         .right_entry (row[k+2]),
         .place_in    (place[k]),
         .entry       (row[k+1]),
         .place_out   (place[k+1])
      );
   end

   assign report_entry = row[2];

endmodule

FILE: rtl/feature_distance_top_n_ranker_core.sv
// feature_distance_top_n_ranker_core: top level of the histogram top-n ranker
// configuration registers, ranking control and result register
// depends on fdr_pkg, fdr_score_path, fdr_rank_list
//
//   channel | ports                          | direction | carries
//   req     | req_valid req_ready req_data   | in        | req_type: op, bin, image id
//   rsp     | rsp_valid rsp_ready rsp_data   | out       | rsp_type: one ranked match
//   csr     | csr_we csr_index csr_wdata     | in        | register write, no wait
//
// load and database bins transfer one per cycle while req_ready is high; a vector's
// score passes the memory-access, term and accumulate registers to the list and is
// inserted by the cell row. a finish holds req_ready low while it passes them, then
// one match leaves per cycle through the result register when rsp_ready allows.
// rsp stalls slow the ranking and keep req_ready low until its last match is loaded;
// reset is synchronous and clears the list.
`timescale 1ns / 1ps

module feature_distance_top_n_ranker_core
   import fdr_pkg::*;
#(
   parameter int BINS    = 512,
   parameter int TOP_MAX = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   localparam int DEPTH = TOP_MAX + 1;
   localparam int HW    = $clog2(DEPTH + 1);
   localparam int WW    = (HW > 5) ? HW : 5;

   logic       mode_ff;
   logic [9:0] len_ff;
   logic [4:0] count_ff;

   score_evt_type evt;
   logic          fin_busy;
   logic          req_take;

   list_cmd_type cmd;
   entry_type    report_entry;

   logic [HW-1:0] held_ff, held_in;
   logic          emit_ff, emit_in;
   logic [WW-1:0] n_ff, n_in, k_ff, k_in;
   logic [WW-1:0] want, held_m1, n_calc;
   logic          load_rsp, last_rsp;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         len_ff   <= 10'd512;
         count_ff <= 5'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_METRIC_MODE:   mode_ff  <= csr_wdata[0];
            CSR_VECTOR_LENGTH: len_ff   <= csr_wdata;
            CSR_TOP_COUNT:     count_ff <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = !emit_ff && !fin_busy;
   assign req_take  = req_valid && req_ready;

   fdr_score_path #(
      .BINS (BINS)
   ) u_score (
      .clock         (clock),
      .reset         (reset),
      .item_take     (req_take),
      .item          (req_data),
      .metric_mode   (mode_ff),
      .vector_length (len_ff),
      .evt           (evt),
      .fin_busy      (fin_busy)
   );

   always_comb begin
      want    = (WW'(count_ff) > WW'(TOP_MAX)) ? WW'(TOP_MAX) : WW'(count_ff);
      held_m1 = (held_ff == '0) ? '0 : (WW'(held_ff) - WW'(1));
      n_calc  = (held_m1 > want) ? want : held_m1;

      load_rsp = emit_ff && (!rsp_valid_ff || rsp_ready);
      last_rsp = (k_ff + WW'(1)) == n_ff;

      cmd       = '0;
      cmd.mode  = mode_ff;
      cmd.score = evt.score;
      cmd.id    = evt.id;

      held_in = held_ff;
      emit_in = emit_ff;
      n_in    = n_ff;
      k_in    = k_ff;

      if (evt.ins) begin
         cmd.insert = 1'b1;
         if (held_ff < HW'(DEPTH)) begin
            held_in = held_ff + HW'(1);
         end
      end else if (evt.fin) begin
         n_in = n_calc;
         k_in = '0;
         if (n_calc == '0) begin
            cmd.clear = 1'b1;
            held_in   = '0;
         end else begin
            emit_in = 1'b1;
         end
      end else if (load_rsp) begin
         k_in = k_ff + WW'(1);
         if (last_rsp) begin
            cmd.clear = 1'b1;
            held_in   = '0;
            emit_in   = 1'b0;
         end else begin
            cmd.shift_up = 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.match_id      = report_entry.id;
         rsp_data_in.match_score   = report_entry.score;
         rsp_data_in.rank_position = k_ff[3:0];
         rsp_data_in.rank_last     = last_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   fdr_rank_list #(
      .DEPTH (DEPTH)
   ) u_list (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .report_entry (report_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         emit_ff      <= 1'b0;
         n_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         emit_ff      <= emit_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: verif/tb_feature_distance_top_n_ranker_core.sv
// tb_feature_distance_top_n_ranker_core: self-checking bench for the top-n ranker core
// predicts each ranking from its own copy of the query, score and sorted-list state
// depends on fdr_pkg and feature_distance_top_n_ranker_core
`timescale 1ns / 1ps

module tb_feature_distance_top_n_ranker_core;
   import fdr_pkg::*;

   localparam int BINS           = 512;
   localparam int TOP_MAX        = 16;
   localparam int LIST_DEPTH     = TOP_MAX + 1;
   localparam int SETTLE         = 12;
   localparam int LONG_HOLD      = 200;
   localparam int RANDOM_ITEMS   = 55;

   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [9:0]  csr_wdata = '0;

   // predicted block state
   logic               m_mode = 1'b0;
   logic [9:0]         m_length = 10'd512;
   logic [4:0]         m_top = 5'd10;
   logic [BIN_W-1:0]   m_query [BINS];
   bit                 m_written [BINS];
   int                 m_pos = 0;
   logic [SCORE_W-1:0] m_acc = '0;
   logic [SCORE_W-1:0] m_scores [LIST_DEPTH];
   logic [ID_W-1:0]    m_ids [LIST_DEPTH];
   bit                 m_valid [LIST_DEPTH];

   rsp_type ranking_expect [$];
   int      errors = 0;
   int      random_sent = 0;
   bit      quiet_mode = 1'b0;
   bit      hold_rsp_go = 1'b0;
   int      hold_left = 0;
   int      gap_left = 0;

   feature_distance_top_n_ranker_core #(
      .BINS(BINS),
      .TOP_MAX(TOP_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("FAIL feature_distance_top_n_ranker_core");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [BIN_W-1:0] rand_bin();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return BIN_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic int eff_length();
      if (m_length == 0) return 1;
      if (m_length > BINS) return BINS;
      return int'(m_length);
   endfunction

   // shared bin counter; true on the last bin of a vector
   function automatic bit step_bin_counter();
      if (m_pos + 1 >= eff_length()) begin
         m_pos = 0;
         return 1'b1;
      end
      m_pos++;
      return 1'b0;
   endfunction

   task automatic insert_score(input logic [SCORE_W-1:0] score, input logic [ID_W-1:0] id);
      int  slot;
      bit  found;
      slot = LIST_DEPTH;
      found = 1'b0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         if (!found) begin
            if (!m_valid[k] || (m_mode ? (score < m_scores[k]) : (score > m_scores[k]))) begin
               slot = k;
               found = 1'b1;
            end
         end
      end
      if (found) begin
         for (int k = LIST_DEPTH - 1; k > slot; k--) begin
            m_scores[k] = m_scores[k-1];
            m_ids[k]    = m_ids[k-1];
            m_valid[k]  = m_valid[k-1];
         end
         m_scores[slot] = score;
         m_ids[slot]    = id;
         m_valid[slot]  = 1'b1;
      end
   endtask

   task automatic predict_transfer(input req_type item);
      int          pos;
      int          held;
      int          n;
      int          want;
      logic [63:0] q;
      logic [63:0] b;
      logic [63:0] term;
      logic [63:0] limit;
      rsp_type     e;
      pos = m_pos % BINS;
      limit = {{(64-SCORE_W){1'b0}}, SCORE_MAX};
      case (item.operation)
         OP_LOAD_QUERY: begin
            m_query[pos] = item.bin_value;
            m_written[pos] = 1'b1;
            void'(step_bin_counter());
         end
         OP_DATABASE: begin
            q = 64'(m_query[pos]);
            b = 64'(item.bin_value);
            if (m_mode) begin
               term = (q > b) ? q - b : b - q;
               term = term * term;
            end else begin
               term = (q < b) ? q : b;
            end
            if ({{(64-SCORE_W){1'b0}}, m_acc} > limit - term) m_acc = SCORE_MAX;
            else m_acc = m_acc + term[SCORE_W-1:0];
            if (step_bin_counter()) begin
               insert_score(m_acc, item.image_id);
               m_acc = '0;
            end
         end
         OP_FINISH: begin
            want = (m_top > TOP_MAX) ? TOP_MAX : int'(m_top);
            held = 0;
            for (int k = 0; k < LIST_DEPTH; k++) if (m_valid[k]) held++;
            n = (held > 1) ? held - 1 : 0;
            if (n > want) n = want;
            for (int k = 0; k < n; k++) begin
               e.match_id      = m_ids[k+1];
               e.match_score   = m_scores[k+1];
               e.rank_position = k[3:0];
               e.rank_last     = (k + 1 == n);
               ranking_expect  = {ranking_expect, e};
            end
            for (int k = 0; k < LIST_DEPTH; k++) begin
               m_scores[k] = '0;
               m_ids[k]    = '0;
               m_valid[k]  = 1'b0;
            end
            m_acc = '0;
            m_pos = 0;
         end
         default: begin
         end
      endcase
   endtask

   // one input transfer; a database bin over a never-loaded query bin becomes a load
   task automatic send_op(input logic [1:0] op, input logic [BIN_W-1:0] bin,
                          input logic [ID_W-1:0] id);
      req_type item;
      int      gap;
      if (op == OP_DATABASE && !m_written[m_pos % BINS]) op = OP_LOAD_QUERY;
      item.operation = op;
      item.bin_value = bin;
      item.image_id  = id;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_transfer(item);
   endtask

   task automatic send_counted(input logic [1:0] op, input logic [BIN_W-1:0] bin,
                               input logic [ID_W-1:0] id);
      send_op(op, bin, id);
      random_sent++;
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ranking_expect.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(input logic mode, input logic [9:0] len, input logic [4:0] top,
                            input bit poke_unused);
      settle_block();
      csr_we    <= 1'b1;
      csr_index <= CSR_METRIC_MODE;
      csr_wdata <= {9'd0, mode};
      @(posedge clock);
      m_mode = mode;
      csr_index <= CSR_VECTOR_LENGTH;
      csr_wdata <= len;
      @(posedge clock);
      m_length = len;
      csr_index <= CSR_TOP_COUNT;
      csr_wdata <= {5'd0, top};
      @(posedge clock);
      m_top = top;
      if (poke_unused) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= 10'($urandom_range(0, 1023));
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic report_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (ranking_expect.size() == 0) begin
            errors++;
            $display("%0t unexpected match: expected none actual %h", $time, rsp_data);
         end else begin
            want = ranking_expect.pop_front();
            report_field("match_id", 64'(want.match_id), 64'(rsp_data.match_id));
            report_field("match_score", 64'(want.match_score), 64'(rsp_data.match_score));
            report_field("rank_position", 64'(want.rank_position),
                         64'(rsp_data.rank_position));
            report_field("rank_last", 64'(want.rank_last), 64'(rsp_data.rank_last));
         end
      end
   end

   // result-side pacing, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_rsp_go) begin
         hold_rsp_go = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (gap_left > 0) begin
         rsp_ready <= 1'b0;
         gap_left--;
      end else begin
         rsp_ready <= 1'b1;
         gap_left = pick_gap();
      end
   end

   task automatic test_intersection_ties();
      configure(1'b0, 10'd2, 5'd16, 1'b1);
      send_op(OP_LOAD_QUERY, 16'hFFFF, 16'h0000);
      send_op(OP_LOAD_QUERY, 16'd40000, 16'h0000);
      // id of a vector comes from its last bin; ignored op mid-vector
      send_op(OP_DATABASE, 16'hFFFF, 16'h1111);
      send_op(OP_IGNORED, 16'hFFFF, 16'hFFFF);
      send_op(OP_DATABASE, 16'hFFFF, 16'hFFFF);
      send_op(OP_DATABASE, 16'h0000, 16'h0000);
      send_op(OP_DATABASE, 16'h0000, 16'h0000);
      send_op(OP_DATABASE, 16'h0000, 16'h0002);
      send_op(OP_DATABASE, 16'h0000, 16'h0002);
      send_op(OP_FINISH, 16'h0000, 16'h0000);
   endtask

   task automatic test_distance_top_one();
      configure(1'b1, 10'd2, 5'd1, 1'b0);
      send_op(OP_DATABASE, 16'h0000, 16'h00AA);
      send_op(OP_DATABASE, 16'h0000, 16'h00AA);
      send_op(OP_DATABASE, 16'hFFFF, 16'h5555);
      send_op(OP_DATABASE, 16'd40000, 16'h5555);
      send_op(OP_DATABASE, 16'hFFFF, 16'hAAAA);
      send_op(OP_DATABASE, 16'd40000, 16'hAAAA);
      send_op(OP_FINISH, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_short_lists();
      // zero length acts as one, oversized count as the maximum
      configure(1'b0, 10'd0, 5'd31, 1'b0);
      send_op(OP_FINISH, 16'h0000, 16'h0000);
      send_op(OP_DATABASE, 16'hFFFF, 16'h0007);
      send_op(OP_FINISH, 16'h0000, 16'h0000);
      configure(1'b0, 10'd1, 5'd0, 1'b0);
      send_op(OP_DATABASE, 16'd100, 16'h0001);
      send_op(OP_DATABASE, 16'd200, 16'h0002);
      send_op(OP_FINISH, 16'h0000, 16'h0000);
   endtask

   task automatic test_output_backpressure();
      configure(1'b0, 10'd1, 5'd16, 1'b0);
      send_op(OP_LOAD_QUERY, rand_bin(), 16'h0000);
      for (int k = 0; k < 19; k++) send_op(OP_DATABASE, rand_bin(), k[15:0]);
      hold_rsp_go = 1'b1;
      send_op(OP_FINISH, 16'h0000, 16'h0000);
      for (int k = 0; k < 20; k++)
         send_op(OP_DATABASE, rand_bin(), ID_W'($urandom_range(0, 65535)));
      send_op(OP_FINISH, 16'h0000, 16'h0000);
   endtask

   task automatic test_random_ranking();
      int          phase;
      int          n_vec;
      int          left;
      int          r;
      logic [9:0]  len;
      logic [4:0]  top;
      logic [15:0] id;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         quiet_mode = (phase < 2);
         r = $urandom_range(0, 9);
         len = (r == 0) ? 10'd0 : (r == 1) ? 10'($urandom_range(9, 24)) :
               10'($urandom_range(1, 6));
         r = $urandom_range(0, 7);
         top = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31)) :
               (r == 2) ? 5'd16 : 5'($urandom_range(1, 15));
         configure(1'($urandom_range(0, 1)), len, top, 1'b0);
         if (phase == 0 || $urandom_range(0, 3) == 0)
            repeat (eff_length())
               send_counted(OP_LOAD_QUERY, rand_bin(), ID_W'($urandom_range(0, 65535)));
         n_vec = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 5);
         repeat (n_vec) begin
            id = ID_W'($urandom_range(0, 65535));
            left = (m_pos < eff_length()) ? eff_length() - m_pos : 1;
            repeat (left) begin
               r = $urandom_range(0, 99);
               if (r < 3) send_op(OP_IGNORED, rand_bin(), ID_W'($urandom_range(0, 65535)));
               else if (r < 6) send_counted(OP_LOAD_QUERY, rand_bin(), id);
               else if (r < 8) send_counted(OP_FINISH, rand_bin(), id);
               else send_counted(OP_DATABASE, rand_bin(),
                                 (r < 18) ? ID_W'($urandom_range(0, 65535)) : id);
            end
         end
         if ($urandom_range(0, 3) != 0)
            send_counted(OP_FINISH, rand_bin(), ID_W'($urandom_range(0, 65535)));
         phase++;
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      for (int k = 0; k < BINS; k++) m_query[k] = '0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         m_scores[k] = '0;
         m_ids[k]    = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_intersection_ties();
      test_distance_top_one();
      test_short_lists();
      test_output_backpressure();
      test_random_ranking();
      settle_block();
      if (ranking_expect.size() != 0) begin
         errors += ranking_expect.size();
         $display("%0t missing matches: expected %0d more actual 0", $time,
                  ranking_expect.size());
      end
      if (errors == 0) begin
         $display("PASS feature_distance_top_n_ranker_core");
      end else begin
         $display("FAIL feature_distance_top_n_ranker_core");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/fdr_pkg.sv
rtl/fdr_score_path.sv
rtl/fdr_rank_cell.sv
rtl/fdr_rank_list.sv
rtl/feature_distance_top_n_ranker_core.sv
verif/tb_feature_distance_top_n_ranker_core.sv
